// ----- hdl/ssf_pkg.sv -----
package ssf_pkg;

  localparam int BYTE_W     = 8;
  localparam int WINDOW_MAX = 16;
  localparam int SEL_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W      = 5;
  localparam int IDX_W      = 16;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  // pattern as seen from the window: expected[k] is compared with the k-th newest byte
  typedef struct packed {
    logic [WINDOW_MAX-1:0][BYTE_W-1:0] expected;
    logic [WINDOW_MAX-1:0]             mask;
    logic [LEN_W-1:0]                  used_len;
  } pattern_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_start;
    logic             text_done;
    logic             overflow;
  } result_t;

endpackage

// ----- hdl/ssf_pattern.sv -----
module ssf_pattern import ssf_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output pattern_t             pat
);

  logic [CFG_W-1:0] pattern_low;
  logic [CFG_W-1:0] pattern_high;
  logic [LEN_W-1:0] pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2*CFG_W-1:0]                pat_word;
  logic [WINDOW_MAX-1:0][BYTE_W-1:0] pat_bytes;
  logic [LEN_W-1:0]                  cap_len;
  logic [LEN_W-1:0]                  used;
  logic [LEN_W-1:0]                  ridx [WINDOW_MAX];

  assign pat_word = {pattern_high, pattern_low};

  always_comb begin
    for (int k = 0; k < WINDOW_MAX; k++) begin
      pat_bytes[k] = pat_word[BYTE_W*k +: BYTE_W];
    end
    cap_len = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_length;
    // a zero byte ends the pattern early
    used = cap_len;
    for (int k = WINDOW_MAX - 1; k >= 0; k--) begin
      if ((LEN_W'(k) < cap_len) && (pat_bytes[k] == '0)) used = LEN_W'(k);
    end
    for (int k = 0; k < WINDOW_MAX; k++) begin
      ridx[k]         = used - LEN_W'(k) - LEN_W'(1);
      pat.mask[k]     = LEN_W'(k) < used;
      pat.expected[k] = pat_bytes[ridx[k][SEL_W-1:0]];
    end
    pat.used_len = used;
  end

endmodule

// ----- hdl/ssf_scan.sv -----
module ssf_scan import ssf_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [BYTE_W-1:0] text_byte,
  input  pattern_t          pat,
  output result_t           result
);

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window;
  logic [IDX_W-1:0]                   text_index;
  logic                               match_latched;
  logic [IDX_W-1:0]                   first_match_index;
  logic                               index_saturated;

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_next;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_shift;
  logic [IDX_W-1:0]                   text_index_next;
  logic                               match_latched_next;
  logic [IDX_W-1:0]                   first_match_index_next;
  logic                               index_saturated_next;
  result_t                            result_next;
  logic                               hit;
  logic [IDX_W-1:0]                   back;
  logic [IDX_W-1:0]                   start;

  always_comb begin
    win_shift[0] = text_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_shift[i] = window[i-1];
    end
    hit = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (pat.mask[k] && (win_shift[k] != pat.expected[k])) hit = 1'b0;
    end
    back = IDX_W'(pat.used_len) - IDX_W'(1);
    if (pat.used_len == '0) begin
      start = text_index;
    end else if (text_index >= back) begin
      start = text_index - back;
    end else begin
      start = '0;
    end

    if (text_byte == '0) begin
      window_next            = '0;
      text_index_next        = '0;
      match_latched_next     = 1'b0;
      first_match_index_next = '0;
      index_saturated_next   = 1'b0;
      result_next.found       = match_latched;
      result_next.match_start = first_match_index;
      result_next.text_done   = 1'b1;
      result_next.overflow    = index_saturated;
    end else begin
      window_next            = win_shift;
      match_latched_next     = match_latched | hit;
      first_match_index_next = (!match_latched && hit) ? start : first_match_index;
      text_index_next        = (text_index == IDX_MAX) ? IDX_MAX : text_index + IDX_W'(1);
      index_saturated_next   = index_saturated | (text_index == IDX_MAX);
      result_next.found       = match_latched_next;
      result_next.match_start = first_match_index_next;
      result_next.text_done   = 1'b0;
      result_next.overflow    = index_saturated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window            <= '0;
      text_index        <= '0;
      match_latched     <= 1'b0;
      first_match_index <= '0;
      index_saturated   <= 1'b0;
    end else if (advance) begin
      window            <= window_next;
      text_index        <= text_index_next;
      match_latched     <= match_latched_next;
      first_match_index <= first_match_index_next;
      index_saturated   <= index_saturated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

`ifndef SYNTHESIS
  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    (advance && text_byte == '0) |=>
      (text_index == '0 && !match_latched && !index_saturated && first_match_index == '0))
    else $error("text state not cleared after terminator");

  a_sat_index: assert property (@(posedge clk) disable iff (rst)
    index_saturated |-> text_index == IDX_MAX)
    else $error("overflow flag set with index below maximum");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    !match_latched |-> first_match_index == '0)
    else $error("match start set without a match");

  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && match_latched && text_byte != '0) |=>
      (match_latched && $stable(first_match_index)))
    else $error("first match changed inside a text");
`endif

endmodule

// ----- hdl/streaming_substring_finder.sv -----
// Substring finder over a byte stream. Each accepted text byte produces
// exactly one result transfer; a zero byte ends the text, its result
// carries tlast and the outcome of that text, and the scan restarts.
// The pattern (up to PATTERN_MAX nonzero bytes, ending early at its first
// zero byte) is compared in parallel against a window of the newest bytes.
// Throughput is one byte per cycle unless m_tready stalls the output. Bytes
// pass the input register, then window shift and compare feed the result
// register combinationally. The user must write pattern registers through
// the cfg port only while no text byte is in flight; nothing enforces it.
module streaming_substring_finder import ssf_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] text_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [15:0] match_start
  output logic [1:0]           m_tuser,   // [0] found, [1] position_overflow
  output logic                 m_tlast    // text_done
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  pattern_t          pat;
  result_t           result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  ssf_pattern #(.PATTERN_MAX(PATTERN_MAX)) u_pattern (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  ssf_scan #(.PATTERN_MAX(PATTERN_MAX)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .text_byte (in_byte),
    .pat       (pat),
    .result    (result)
  );

  assign m_tdata = result.match_start;
  assign m_tuser = {result.overflow, result.found};
  assign m_tlast = result.text_done;

endmodule
